// ----- sv/vru_pkg.sv -----
// shared types, constants and arithmetic helpers for the vector refraction pipeline
package vru_pkg;

  localparam int Lanes    = 4;
  localparam int Comps    = 4;
  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int WideW    = ProdW + 2;
  localparam int CntW     = 3;
  localparam int SqSteps  = 4;
  localparam int SqStages = (DataW - 1 + FracBits + 2 * SqSteps - 1) / (2 * SqSteps);
  localparam int RootW    = SqSteps * SqStages;
  localparam int RadW     = 2 * RootW;
  localparam int RemW     = RootW + 3;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [WideW-1:0] wide_t;

  localparam wide_t One = wide_t'(1) <<< FracBits;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  typedef struct packed {
    prod_t [Lanes-1:0] ei;
    q_t [Lanes-1:0]    nrm;
    q_t                em;
    logic [Lanes-1:0]  mask;
    logic              tir;
  } side_t;

  function automatic q_t sat32(input wide_t x);
    q_t r;
    if (x[WideW-1:DataW-1] == '0 || x[WideW-1:DataW-1] == '1) begin
      r = x[DataW-1:0];
    end else if (x[WideW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic wide_t fshift(input prod_t p);
    prod_t s;
    s = p >>> FracBits;
    return wide_t'(s);
  endfunction

  function automatic prod_t qmul(input q_t a, input q_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic sq_t sq_step(input sq_t a);
    sq_t r;
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    r = a;
    for (int i = 0; i < SqSteps; i++) begin
      rem2  = {r.rem[RemW-3:0], r.rad[RadW-1 -: 2]};
      trial = {1'b0, r.root, 2'b01};
      if (rem2 >= trial) begin
        r.rem  = rem2 - trial;
        r.root = {r.root[RootW-2:0], 1'b1};
      end else begin
        r.rem  = rem2;
        r.root = {r.root[RootW-2:0], 1'b0};
      end
      r.rad = {r.rad[RadW-3:0], 2'b00};
    end
    return r;
  endfunction

endpackage

// ----- sv/vru_front.sv -----
// front pipeline: dot product, eta squared and the k term, six stages
module vru_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  vru_pkg::q_t [vru_pkg::Lanes-1:0]  inc_i,
  input  vru_pkg::q_t [vru_pkg::Lanes-1:0]  nrm_i,
  input  vru_pkg::q_t                       eta_i,
  input  logic [vru_pkg::CntW-1:0]          act_i,
  output logic                              valid_o,
  output vru_pkg::q_t                       k_o,
  output vru_pkg::side_t                    side_o
);

  logic [vru_pkg::CntW-1:0] act_eff;
  logic [vru_pkg::Lanes-1:0] mask_d;
  vru_pkg::wide_t dot_d;

  logic [5:0] v_q;

  vru_pkg::prod_t [vru_pkg::Lanes-1:0] pnn1_q;
  vru_pkg::prod_t pee1_q;
  vru_pkg::q_t eta1_q, eta2_q;
  vru_pkg::side_t sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q;
  vru_pkg::side_t sd1_d, sd4_d, sd6_d;
  vru_pkg::q_t c2_q, e22_q, e23_q, e24_q, t4_q, k6_q;
  vru_pkg::q_t k6_d;
  vru_pkg::prod_t pcc3_q, pec3_q, pet5_q;

  always_comb begin
    if (act_i == '0) begin
      act_eff = vru_pkg::CntW'(1);
    end else if (act_i > vru_pkg::CntW'(vru_pkg::Comps)) begin
      act_eff = vru_pkg::CntW'(vru_pkg::Comps);
    end else begin
      act_eff = act_i;
    end
    for (int j = 0; j < vru_pkg::Lanes; j++) begin
      mask_d[j] = vru_pkg::CntW'(j) < act_eff;
    end
  end

  always_comb begin
    dot_d = '0;
    for (int j = 0; j < vru_pkg::Lanes; j++) begin
      if (sd1_q.mask[j]) begin
        dot_d = dot_d + vru_pkg::fshift(pnn1_q[j]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < vru_pkg::Lanes; j++) begin
      sd1_d.ei[j] = vru_pkg::qmul(eta_i, inc_i[j]);
    end
    sd1_d.nrm  = nrm_i;
    sd1_d.mask = mask_d;
    sd1_d.em   = '0;
    sd1_d.tir  = 1'b0;
    sd4_d      = sd3_q;
    sd4_d.em   = vru_pkg::sat32(vru_pkg::fshift(pec3_q));
    k6_d       = vru_pkg::sat32(vru_pkg::One -
                 vru_pkg::wide_t'(vru_pkg::sat32(vru_pkg::fshift(pet5_q))));
    sd6_d      = sd5_q;
    sd6_d.tir  = k6_d[vru_pkg::DataW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: products
      for (int j = 0; j < vru_pkg::Lanes; j++) begin
        pnn1_q[j] <= vru_pkg::qmul(nrm_i[j], inc_i[j]);
      end
      pee1_q <= vru_pkg::qmul(eta_i, eta_i);
      eta1_q <= eta_i;
      sd1_q  <= sd1_d;
      // stage 2: dot sum, eta squared
      c2_q   <= vru_pkg::sat32(dot_d);
      e22_q  <= vru_pkg::sat32(vru_pkg::fshift(pee1_q));
      eta2_q <= eta1_q;
      sd2_q  <= sd1_q;
      // stage 3: c squared, eta times c
      pcc3_q <= vru_pkg::qmul(c2_q, c2_q);
      pec3_q <= vru_pkg::qmul(eta2_q, c2_q);
      e23_q  <= e22_q;
      sd3_q  <= sd2_q;
      // stage 4: t term
      t4_q <= vru_pkg::sat32(vru_pkg::One -
              vru_pkg::wide_t'(vru_pkg::sat32(vru_pkg::fshift(pcc3_q))));
      e24_q <= e23_q;
      sd4_q <= sd4_d;
      // stage 5: eta squared times t
      pet5_q <= vru_pkg::qmul(e24_q, t4_q);
      sd5_q  <= sd4_q;
      // stage 6: k and total reflection
      k6_q  <= k6_d;
      sd6_q <= sd6_d;
    end
  end

  assign valid_o = v_q[5];
  assign k_o     = k6_q;
  assign side_o  = sd6_q;

endmodule

// ----- sv/vru_sqrt.sv -----
// pipelined digit-by-digit square root of k scaled by the fraction bits
module vru_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  vru_pkg::q_t                 k_i,
  input  vru_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [vru_pkg::RootW-1:0]   root_o,
  output vru_pkg::side_t              side_o
);

  vru_pkg::sq_t sq0;
  vru_pkg::sq_t   sq_q [vru_pkg::SqStages];
  vru_pkg::side_t sd_q [vru_pkg::SqStages];
  logic [vru_pkg::SqStages-1:0] v_q;

  always_comb begin
    sq0.rad  = vru_pkg::RadW'($unsigned(k_i)) << vru_pkg::FracBits;
    sq0.rem  = '0;
    sq0.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[vru_pkg::SqStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0] <= vru_pkg::sq_step(sq0);
      sd_q[0] <= side_i;
      for (int s = 1; s < vru_pkg::SqStages; s++) begin
        sq_q[s] <= vru_pkg::sq_step(sq_q[s-1]);
        sd_q[s] <= sd_q[s-1];
      end
    end
  end

  assign valid_o = v_q[vru_pkg::SqStages-1];
  assign root_o  = sq_q[vru_pkg::SqStages-1].root;
  assign side_o  = sd_q[vru_pkg::SqStages-1];

endmodule

// ----- sv/vru_back.sv -----
// back pipeline: m term, normal scaling and the saturated output word
module vru_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [vru_pkg::RootW-1:0]         root_i,
  input  vru_pkg::side_t                    side_i,
  output logic                              valid_o,
  output vru_pkg::q_t [vru_pkg::Lanes-1:0]  res_o,
  output logic                              tir_o
);

  logic [2:0] v_q;
  vru_pkg::q_t m1_q;
  vru_pkg::side_t sd1_q, sd2_q;
  vru_pkg::prod_t [vru_pkg::Lanes-1:0] pnm2_q;
  vru_pkg::q_t [vru_pkg::Lanes-1:0] res3_q;
  logic tir3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= vru_pkg::sat32(vru_pkg::wide_t'(side_i.em) + vru_pkg::wide_t'(root_i));
      sd1_q <= side_i;
      for (int j = 0; j < vru_pkg::Lanes; j++) begin
        pnm2_q[j] <= vru_pkg::qmul(sd1_q.nrm[j], m1_q);
      end
      sd2_q <= sd1_q;
      for (int j = 0; j < vru_pkg::Lanes; j++) begin
        if (sd2_q.tir || !sd2_q.mask[j]) begin
          res3_q[j] <= '0;
        end else begin
          res3_q[j] <= vru_pkg::sat32(vru_pkg::fshift(sd2_q.ei[j]) -
                                      vru_pkg::fshift(pnm2_q[j]));
        end
      end
      tir3_q <= sd2_q.tir;
    end
  end

  assign valid_o = v_q[2];
  assign res_o   = res3_q;
  assign tir_o   = tir3_q;

endmodule

// ----- sv/vector_refract_unit.sv -----
// top level of the fixed-point vector refraction pipeline
//
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | inc_*_i, nrm_*_i, eta_i, active_components_i
//  out     | valid_o | stall_i | out_*_o, total_reflection_o
//
// one word per cycle unless stall_i holds the pipeline; 6 front stages,
// 6 square-root stages, 3 back stages
// the whole pipeline holds while a finished word waits on stall_i
// reset clears the valid bits only
module vector_refract_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic signed [31:0] inc_x_i,
  input  logic signed [31:0] inc_y_i,
  input  logic signed [31:0] inc_z_i,
  input  logic signed [31:0] inc_w_i,
  input  logic signed [31:0] nrm_x_i,
  input  logic signed [31:0] nrm_y_i,
  input  logic signed [31:0] nrm_z_i,
  input  logic signed [31:0] nrm_w_i,
  input  logic signed [31:0] eta_i,
  input  logic [2:0]        active_components_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_w_o,
  output logic              total_reflection_o
);

  logic en;
  logic f_valid, s_valid;
  vru_pkg::q_t f_k;
  vru_pkg::side_t f_side, s_side;
  logic [vru_pkg::RootW-1:0] s_root;
  vru_pkg::q_t [vru_pkg::Lanes-1:0] inc, nrm, res;

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  assign inc = {inc_w_i, inc_z_i, inc_y_i, inc_x_i};
  assign nrm = {nrm_w_i, nrm_z_i, nrm_y_i, nrm_x_i};

  vru_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .inc_i   (inc),
    .nrm_i   (nrm),
    .eta_i   (eta_i),
    .act_i   (active_components_i),
    .valid_o (f_valid),
    .k_o     (f_k),
    .side_o  (f_side)
  );

  vru_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .k_i     (f_k),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  vru_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (valid_o),
    .res_o   (res),
    .tir_o   (total_reflection_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];
  assign out_w_o = res[3];

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && total_reflection_o |->
      out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && out_w_o == '0)
    else $error("total reflection word carries a non-zero component");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input held without a waiting output word");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(f_valid) && $stable(s_valid))
    else $error("pipeline moved while held");

endmodule
